>>> src/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants of the FIFO / shortest-first task queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_W           = 8;
    localparam int BURST_W         = 16;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_TAIL,
        ST_RESP
    } state_t;

    typedef struct packed
    {
        logic [TAG_W-1:0]   tag;
        logic [BURST_W-1:0] burst;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed
    {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [BURST_W-1:0] burst;
        logic               empty;
        logic               error;
    } result_t;

endpackage

>>> src/fifo_or_shortest_first_queue.sv
// ----------------------------------------------------------------------------
// fifo_or_shortest_first_queue
// Bounded ready queue of tasks in FIFO or shortest-burst-first order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one command per transaction:
//   cmd = enqueue {task_tag, burst_time} or dequeue the head task.
//   Output channel (res_valid / res_ready) returns one transaction per
//   command: the dequeued task (out_valid, out_tag, out_burst), is_empty
//   after the command, and error_flag for an enqueue into a full queue
//   (task dropped) or a dequeue from an empty queue.
//   cfg_wr_en / cfg_wr_data write sort_mode (0 arrival order, 1 ascending
//   burst with ties in arrival order); write it only while idle.
// Timing:
//   Dequeue, FIFO enqueue and any error pass from EXEC straight to RESP,
//   which loads the result register; a sorted enqueue into a non-empty
//   queue first walks forward through the entry RAM in WALK, one held entry
//   per cycle, and writes the last entry in TAIL. in_ready rises again with
//   the load, so a new command is accepted only once the last one is done.
// Reset:
//   Clears the count, head pointer, sort_mode and the result valid; the RAM
//   and the result payload are not cleared, and entries are read only below
//   the count.
// Stall:
//   A held result waits in the output register; a finished command holds
//   in its response step until the register frees, and no new command is
//   accepted meanwhile.
// ----------------------------------------------------------------------------
module fifo_or_shortest_first_queue #(
    parameter int QUEUE_DEPTH = sfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [sfq_pkg::TAG_W-1:0]   task_tag,
    input  logic [sfq_pkg::BURST_W-1:0] burst_time,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        out_valid,
    output logic [sfq_pkg::TAG_W-1:0]   out_tag,
    output logic [sfq_pkg::BURST_W-1:0] out_burst,
    output logic                        is_empty,
    output logic                        error_flag
);

    import sfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          sort_mode_reg, sort_mode_next;
    logic          res_valid_reg, res_valid_next;
    result_t       out_reg;
    logic          slot_free;
    logic          res_load;
    result_t       res;
    logic [CW-1:0] count;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;

    // Entry store: one RAM, head-relative circular layout
    sfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .task_tag   (task_tag),
        .burst_time (burst_time),
        .sort_mode  (sort_mode_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .slot_free  (slot_free),
        .res_load   (res_load),
        .res        (res),
        .count      (count)
    );

    // Output register is free when empty or being drained this cycle
    assign slot_free = !res_valid_reg || res_ready;

    always_comb
    begin
        sort_mode_next = cfg_wr_en ? cfg_wr_data : sort_mode_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sort_mode_reg <= sort_mode_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the payload until a new result is loaded
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_valid  = out_reg.valid;
    assign out_tag    = out_reg.tag;
    assign out_burst  = out_reg.burst;
    assign is_empty   = out_reg.empty;
    assign error_flag = out_reg.error;

    // Never overwrite a result that is still waiting
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> slot_free)
        else $error("result loaded over a pending transaction");

    // Count stays within the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // A returned task and an error never come together
    a_valid_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid && error_flag))
        else $error("result carries both a task and an error");

    // A loaded result is presented in the next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> res_valid)
        else $error("loaded result not presented");

    // No result is produced while the block waits for a command
    a_idle_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_load)
        else $error("result loaded while idle");

endmodule

>>> src/sfq_ram.sv
// ----------------------------------------------------------------------------
// sfq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sfq_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/sfq_ctrl.sv
// ----------------------------------------------------------------------------
// sfq_ctrl
// Sequencer of the task queue: circular head pointer and count, and a
// forward walk that ripples entries up by one for a sorted insert.
// ----------------------------------------------------------------------------
module sfq_ctrl #(
    parameter int  QUEUE_DEPTH = sfq_pkg::QUEUE_DEPTH_DEF,
    localparam int AW          = $clog2(QUEUE_DEPTH),
    localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [sfq_pkg::TAG_W-1:0]   task_tag,
    input  logic [sfq_pkg::BURST_W-1:0] burst_time,
    input  logic                        sort_mode,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output sfq_pkg::entry_t             ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  sfq_pkg::entry_t             ram_rdata,
    input  logic                        slot_free,
    output logic                        res_load,
    output sfq_pkg::result_t            res,
    output logic [CW-1:0]               count
);

    import sfq_pkg::*;

    localparam int SW = AW + 1;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] walk_idx_reg, walk_idx_next;
    logic          found_reg, found_next;
    entry_t        carry_reg, carry_next;
    entry_t        new_reg, new_next;
    cmd_t          cmd_reg, cmd_next;
    result_t       res_reg, res_next;
    logic [CW-1:0] walk_idx_inc;

    // Map a queue position to a RAM address (head-relative, wrapping).
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign walk_idx_inc = walk_idx_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_idx_reg <= walk_idx_next;
        found_reg    <= found_next;
        carry_reg    <= carry_next;
        new_reg      <= new_next;
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_ENQ && sort_mode && count_reg != '0 &&
                    count_reg != CW'(QUEUE_DEPTH))
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WALK:
            begin
                if (walk_idx_inc == count_reg)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        walk_idx_next = walk_idx_reg;
        found_next    = found_reg;
        carry_next    = carry_reg;
        new_next      = new_reg;
        cmd_next      = cmd_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = phys(head_reg, count_reg);
        ram_wdata     = new_reg;
        ram_raddr     = head_reg;
        res_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // head is read every idle cycle so it is ready in EXEC
                if (in_valid)
                begin
                    new_next.tag   = task_tag;
                    new_next.burst = burst_time;
                    cmd_next       = cmd_t'(cmd);
                    res_next       = '0;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_DEQ)
                begin
                    if (count_reg == '0)
                    begin
                        res_next.error = 1'b1;
                    end
                    else
                    begin
                        res_next.valid = 1'b1;
                        res_next.tag   = ram_rdata.tag;
                        res_next.burst = ram_rdata.burst;
                        head_next      = (head_reg == AW'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + AW'(1);
                        count_next     = count_reg - CW'(1);
                    end
                end
                else if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res_next.error = 1'b1;
                end
                else if (!sort_mode || count_reg == '0)
                begin
                    // append at the tail
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    // restart the read at the head and walk forward
                    walk_idx_next = '0;
                    found_next    = 1'b0;
                end
            end
            ST_WALK:
            begin
                ram_waddr = phys(head_reg, walk_idx_reg);
                if (found_reg)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = carry_reg;
                    carry_next = ram_rdata;
                end
                else if (ram_rdata.burst > new_reg.burst)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = new_reg;
                    carry_next = ram_rdata;
                    found_next = 1'b1;
                end
                ram_raddr     = phys(head_reg, walk_idx_inc);
                walk_idx_next = walk_idx_inc;
            end
            ST_TAIL:
            begin
                // the displaced last entry, or the new task if nothing was greater
                ram_we     = 1'b1;
                ram_wdata  = found_reg ? carry_reg : new_reg;
                count_next = count_reg + CW'(1);
            end
            ST_RESP:
            begin
                res_load = slot_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res       = res_reg;
        res.empty = (count_reg == '0);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign count    = count_reg;

endmodule
